FILE: design/dfpd_pkg.sv
// Shared types and constants for the direction fair priority dispatcher.
`timescale 1ns / 1ps
package dfpd_pkg;

  localparam int DEF_TABLE_DEPTH  = 128;
  localparam int DEF_STARVE_LIMIT = 2;

  // command codes
  localparam logic CMD_ARRIVE   = 1'b0;
  localparam logic CMD_DISPATCH = 1'b1;

  // last grant direction codes
  localparam logic [1:0] DIR_NONE = 2'd0;
  localparam logic [1:0] DIR_EAST = 2'd1;
  localparam logic [1:0] DIR_WEST = 2'd2;

  localparam logic [1:0] RUN_MAX = 2'd3;

  typedef struct packed {
    logic [7:0]  id;
    logic        west;
    logic        prio;
    logic [31:0] stamp;
  } entry_t;

endpackage

FILE: design/direction_fair_priority_dispatcher.sv
// Arrive or empty dispatch: accept goes straight to DONE, then the result word; else SCAN, DRAIN, REMOVE, DONE.
// A dispatch walks the table once through one comparator, one entry a cycle,
// and only one word is in flight at a time.
// The hole left by a grant is filled by the last entry (one write).
// Reset: synchronous, clears occupancy, grant history and handshakes;
// table contents are left as they are and need no clearing pass.
`timescale 1ns / 1ps
module direction_fair_priority_dispatcher #(
  parameter int TABLE_DEPTH  = dfpd_pkg::DEF_TABLE_DEPTH,
  parameter int STARVE_LIMIT = dfpd_pkg::DEF_STARVE_LIMIT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        command,
  input  logic [7:0]  req_id,
  input  logic        req_direction,
  input  logic        req_priority,
  input  logic [31:0] ready_stamp,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        granted,
  output logic [7:0]  granted_id,
  output logic        granted_direction,
  output logic [7:0]  queue_level,
  output logic        dropped
);
  import dfpd_pkg::*;

  localparam int OCC_W = $clog2(TABLE_DEPTH + 1);
  localparam int IDX_W = $clog2(TABLE_DEPTH);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SCAN   = 3'd1;
  localparam logic [2:0] S_DRAIN  = 3'd2;
  localparam logic [2:0] S_REMOVE = 3'd3;
  localparam logic [2:0] S_DONE   = 3'd4;

  logic [2:0]       state;
  logic [OCC_W-1:0] occupancy;
  logic [OCC_W-1:0] east_count;
  logic [OCC_W-1:0] west_count;
  logic [1:0]       last_dir;
  logic [1:0]       run_length;
  logic [IDX_W-1:0] scan_idx;
  logic [IDX_W-1:0] data_idx;
  logic [IDX_W-1:0] best_idx;
  logic             rd_vld;
  logic             have_best;
  entry_t           best_entry;
  entry_t           last_entry;
  entry_t           rd_entry;
  entry_t           new_entry;
  entry_t           wr_data;
  logic             res_granted;
  logic [7:0]       res_id;
  logic             res_dir;
  logic             res_dropped;

  logic             accept;
  logic             full;
  logic [OCC_W-1:0] occ_m1;
  logic [IDX_W-1:0] last_idx;
  logic             arrive_wr;
  logic             only_opp;
  logic             eligible;
  logic             win;
  logic             take;
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  logic [1:0]       grant_code;
  logic             out_free;

  assign in_ready  = (state == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign full      = (occupancy == OCC_W'(TABLE_DEPTH));
  assign occ_m1    = occupancy - 1'b1;
  assign last_idx  = occ_m1[IDX_W-1:0];
  assign new_entry = '{id: req_id, west: req_direction, prio: req_priority, stamp: ready_stamp};
  assign arrive_wr = accept && (command == CMD_ARRIVE) && !full;
  assign out_free  = !out_valid || out_ready;

  // starvation guard: once the run reaches STARVE_LIMIT, only the other direction may win while it has waiters
  assign only_opp = (run_length >= 2'(STARVE_LIMIT)) &&
                    (((last_dir == DIR_EAST) && (west_count != '0)) ||
                     ((last_dir == DIR_WEST) && (east_count != '0)));
  assign eligible = !only_opp || (rd_entry.west != (last_dir == DIR_WEST));
  assign take     = rd_vld && eligible && (!have_best || win);

  assign wr_en      = arrive_wr || (state == S_REMOVE);
  assign wr_addr    = (state == S_REMOVE) ? best_idx : occupancy[IDX_W-1:0];
  assign wr_data    = (state == S_REMOVE) ? last_entry : new_entry;
  assign grant_code = best_entry.west ? DIR_WEST : DIR_EAST;

  dfpd_table #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (state == S_SCAN),
    .rd_addr (scan_idx),
    .rd_data (rd_entry)
  );

  dfpd_cmp u_cmp (
    .challenger (rd_entry),
    .incumbent  (best_entry),
    .last_dir   (last_dir),
    .win        (win)
  );

  // sequencer and control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      occupancy  <= '0;
      east_count <= '0;
      west_count <= '0;
      last_dir   <= DIR_NONE;
      run_length <= 2'd0;
      scan_idx   <= '0;
      rd_vld     <= 1'b0;
      have_best  <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      rd_vld <= (state == S_SCAN);
      if (take) begin
        have_best <= 1'b1;
      end
      if ((state == S_DONE) && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            if (command == CMD_ARRIVE) begin
              if (!full) begin
                occupancy <= occupancy + 1'b1;
                if (req_direction) begin
                  west_count <= west_count + 1'b1;
                end else begin
                  east_count <= east_count + 1'b1;
                end
              end
              state <= S_DONE;
            end else if (occupancy == '0) begin
              state <= S_DONE;
            end else begin
              scan_idx  <= '0;
              have_best <= 1'b0;
              state     <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          scan_idx <= scan_idx + 1'b1;
          if (scan_idx == last_idx) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          state <= S_REMOVE;
        end
        S_REMOVE: begin
          occupancy <= occ_m1;
          if (best_entry.west) begin
            west_count <= west_count - 1'b1;
          end else begin
            east_count <= east_count - 1'b1;
          end
          if (last_dir == grant_code) begin
            if (run_length != RUN_MAX) begin
              run_length <= run_length + 2'd1;
            end
          end else begin
            run_length <= 2'd1;
          end
          last_dir <= grant_code;
          state    <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    data_idx <= scan_idx;
    if (take) begin
      best_entry <= rd_entry;
      best_idx   <= data_idx;
    end
    // the last entry read moves into the granted slot
    if (rd_vld && (data_idx == last_idx)) begin
      last_entry <= rd_entry;
    end
    if (accept) begin
      res_granted <= 1'b0;
      res_id      <= 8'd0;
      res_dir     <= 1'b0;
      res_dropped <= (command == CMD_ARRIVE) && full;
    end
    if (state == S_REMOVE) begin
      res_granted <= 1'b1;
      res_id      <= best_entry.id;
      res_dir     <= best_entry.west;
    end
    if ((state == S_DONE) && out_free) begin
      granted           <= res_granted;
      granted_id        <= res_id;
      granted_direction <= res_dir;
      queue_level       <= 8'(occupancy);
      dropped           <= res_dropped;
    end
  end

`ifndef NO_ASSERTIONS
  a_count_sum: assert property (@(posedge clk) disable iff (rst)
    ({1'b0, east_count} + {1'b0, west_count}) == {1'b0, occupancy})
    else $error("direction counts disagree with occupancy");

  a_occ_bound: assert property (@(posedge clk) disable iff (rst)
    occupancy <= OCC_W'(TABLE_DEPTH))
    else $error("occupancy above table depth");

  a_run_hist: assert property (@(posedge clk) disable iff (rst)
    (run_length == 2'd0) == (last_dir == DIR_NONE))
    else $error("run length out of step with grant history");

  a_one_word: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("second word taken while one is in work");
`endif

endmodule

FILE: design/dfpd_table.sv
// Requester table: one write port, one registered read port.
`timescale 1ns / 1ps
module dfpd_table #(
  parameter int TABLE_DEPTH = dfpd_pkg::DEF_TABLE_DEPTH
) (
  input  logic                           clk,
  input  logic                           wr_en,
  input  logic [$clog2(TABLE_DEPTH)-1:0] wr_addr,
  input  dfpd_pkg::entry_t               wr_data,
  input  logic                           rd_en,
  input  logic [$clog2(TABLE_DEPTH)-1:0] rd_addr,
  output dfpd_pkg::entry_t               rd_data
);
  import dfpd_pkg::*;

  entry_t mem [TABLE_DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: design/dfpd_cmp.sv
// Ranking compare: does the challenger displace the current best entry.
`timescale 1ns / 1ps
module dfpd_cmp (
  input  dfpd_pkg::entry_t challenger,
  input  dfpd_pkg::entry_t incumbent,
  input  logic [1:0]       last_dir,
  output logic             win
);
  import dfpd_pkg::*;

  always_comb begin
    if (challenger.prio != incumbent.prio) begin
      win = challenger.prio;
    end else if (challenger.west == incumbent.west) begin
      win = (challenger.stamp < incumbent.stamp) ||
            ((challenger.stamp == incumbent.stamp) && (challenger.id < incumbent.id));
    end else if (last_dir == DIR_NONE) begin
      win = challenger.west;
    end else begin
      // incumbent loses when it runs the same way as the last grant
      win = incumbent.west ? (last_dir == DIR_WEST) : (last_dir == DIR_EAST);
    end
  end

endmodule
